FILE: rtl/bcdl_pkg.sv
// Shared types and constants for the button click, double click and long press classifier.
package bcdl_pkg;

  // Configuration registers are 16 bits wide.
  localparam int CFG_W = 16;
  localparam int SEL_W = 3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DOUBLE_WINDOW  = 2'd0;
  localparam logic [1:0] CFG_LONG_THRESHOLD = 2'd1;

  // Register reset values.
  localparam logic [CFG_W-1:0] DOUBLE_WINDOW_RST  = 16'd50;
  localparam logic [CFG_W-1:0] LONG_THRESHOLD_RST = 16'd150;

  // Selection range is 1 to 4.
  localparam logic [SEL_W-1:0] SEL_MIN = 3'd1;
  localparam logic [SEL_W-1:0] SEL_MAX = 3'd4;
  localparam logic [SEL_W:0]   SEL_MOD = 4'd5;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_CLICK  = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } ev_t;

  typedef struct packed {
    logic [CFG_W-1:0] double_window;
    logic [CFG_W-1:0] long_threshold;
  } cfg_t;

endpackage

FILE: rtl/bcdl_click.sv
// Click and double click detector: press tally, double click window and hold counter.
module bcdl_click
  import bcdl_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic step,
  input  logic key_level,
  input  cfg_t cfg,
  output ev_t  click_ev
);

  localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

  logic                  seen_r, seen_nxt;
  logic                  counted_r, counted_nxt;
  logic [1:0]            tally_r, tally_nxt;
  logic [COUNT_BITS-1:0] window_r, window_nxt;
  logic [COUNT_BITS-1:0] hold_r, hold_nxt;
  logic [COUNT_BITS-1:0] window_inc;
  logic [CMP_W-1:0]      win;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  assign win        = CMP_W'(cfg.double_window);
  assign window_inc = sat_inc(window_r);

  always_comb begin
    hold_nxt    = key_level ? '0 : sat_inc(hold_r);
    seen_nxt    = seen_r | ~key_level;
    counted_nxt = counted_r;
    tally_nxt   = tally_r;
    window_nxt  = window_r;
    click_ev    = EV_NONE;

    if (!counted_r) begin
      if (seen_nxt) begin
        tally_nxt   = tally_r + 2'd1;
        counted_nxt = 1'b1;
      end
      if (tally_nxt == 2'd2) begin
        tally_nxt  = 2'd0;
        window_nxt = '0;
        click_ev   = EV_DOUBLE;
      end
    end

    // The tick that reports a double click skips release and window handling.
    if (click_ev != EV_DOUBLE) begin
      if (key_level) begin
        seen_nxt    = 1'b0;
        counted_nxt = 1'b0;
      end
      if (tally_nxt == 2'd1) begin
        window_nxt = window_inc;
        if ((CMP_W'(window_inc) > win) && (CMP_W'(hold_nxt) < win)) begin
          tally_nxt  = 2'd0;
          window_nxt = '0;
          click_ev   = EV_CLICK;
        end else if (CMP_W'(hold_nxt) > win) begin
          tally_nxt  = 2'd0;
          window_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r    <= 1'b0;
      counted_r <= 1'b0;
      tally_r   <= 2'd0;
      window_r  <= '0;
      hold_r    <= '0;
    end else if (step) begin
      seen_r    <= seen_nxt;
      counted_r <= counted_nxt;
      tally_r   <= tally_nxt;
      window_r  <= window_nxt;
      hold_r    <= hold_nxt;
    end
  end

endmodule

FILE: rtl/bcdl_long.sv
// Long press detector: hold counter with threshold compare and repeat.
module bcdl_long
  import bcdl_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic step,
  input  logic key_level,
  input  cfg_t cfg,
  output logic long_fire
);

  localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

  logic                  latch_r, latch_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [COUNT_BITS-1:0] count_step;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  always_comb begin
    count_step = (!latch_r && !key_level) ? sat_inc(count_r) : '0;
    long_fire  = CMP_W'(count_step) > CMP_W'(cfg.long_threshold);
    // After firing, the counter rests at zero for one tick.
    latch_nxt  = long_fire;
    count_nxt  = long_fire ? '0 : count_step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r <= 1'b0;
      count_r <= '0;
    end else if (step) begin
      latch_r <= latch_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

FILE: rtl/bcdl_serve.sv
// Pending event flags, priority service and selection stepping.
module bcdl_serve
  import bcdl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  ev_t              click_ev,
  input  logic             long_fire,
  output ev_t              ev,
  output logic [SEL_W-1:0] sel
);

  logic             pend_click_r, pend_click_nxt;
  logic             pend_double_r, pend_double_nxt;
  logic             pend_long_r, pend_long_nxt;
  logic [SEL_W-1:0] sel_r;
  logic [SEL_W-1:0] sel_down;
  logic [SEL_W:0]   sel_up;

  always_comb begin
    pend_click_nxt  = pend_click_r | (click_ev == EV_CLICK);
    pend_double_nxt = pend_double_r | (click_ev == EV_DOUBLE);
    pend_long_nxt   = pend_long_r | long_fire;

    // Step down with wrap; values outside 1..4 land on 4.
    sel_down = sel_r - 3'd1;
    if ((sel_down > SEL_MAX) || (sel_down == '0)) begin
      sel_down = SEL_MAX;
    end

    // Step up modulo 5, with 0 taken to 1.
    sel_up = {1'b0, sel_r} + 4'd1;
    if (sel_up >= SEL_MOD) begin
      sel_up = sel_up - SEL_MOD;
    end
    if (sel_up == '0) begin
      sel_up = {1'b0, SEL_MIN};
    end

    ev  = EV_NONE;
    sel = sel_r;
    if (pend_click_nxt) begin
      pend_click_nxt = 1'b0;
      ev             = EV_CLICK;
    end else if (pend_double_nxt) begin
      pend_double_nxt = 1'b0;
      sel             = sel_down;
      ev              = EV_DOUBLE;
    end else if (pend_long_nxt) begin
      pend_long_nxt = 1'b0;
      sel           = sel_up[SEL_W-1:0];
      ev            = EV_LONG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_click_r  <= 1'b0;
      pend_double_r <= 1'b0;
      pend_long_r   <= 1'b0;
      sel_r         <= SEL_MIN;
    end else if (step) begin
      pend_click_r  <= pend_click_nxt;
      pend_double_r <= pend_double_nxt;
      pend_long_r   <= pend_long_nxt;
      sel_r         <= sel;
    end
  end

endmodule

FILE: rtl/button_click_double_long_classifier_top.sv
// Top level of the button click, double click and long press classifier.
// Data path: an accepted word is held in the input register and then moves into the result register.
// Throughput: one word per cycle unless the result side stalls, set by the input register feeding the result register.
// Reset (rst_n low, synchronous) clears all detector state and pending events,
// sets the selection to 1, the double window to 50 and the long threshold to 150.
module button_click_double_long_classifier_top
  import bcdl_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  // Configuration write port.
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  // Input channel: one scan tick per word.
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_key_level,
  // Result channel: one result word per tick.
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_event_res,
  output logic [SEL_W-1:0] out_selection
);

  // Configuration registers. Writes to indexes beyond the two registers are dropped.
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.double_window  <= DOUBLE_WINDOW_RST;
      cfg_r.long_threshold <= LONG_THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DOUBLE_WINDOW:  cfg_r.double_window  <= cfg_data;
        CFG_LONG_THRESHOLD: cfg_r.long_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register holds one accepted tick. The result register drains when the
  // consumer takes its word, so the pipeline moves every cycle unless the
  // result side stalls while a word is waiting there.
  logic             in_vld_r;
  logic             key_r;
  logic             out_vld_r;
  logic [1:0]       ev_res_r;
  logic [SEL_W-1:0] sel_res_r;
  logic             out_free;
  logic             step;
  logic             in_take;

  assign out_free = !out_vld_r || !out_stall;
  assign step     = in_vld_r && out_free;
  assign in_stall = in_vld_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (step) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      key_r <= in_key_level;
    end
  end

  // The detectors and the event server advance their state only when the
  // registered tick moves into the result register.
  ev_t              click_ev;
  logic             long_fire;
  ev_t              ev;
  logic [SEL_W-1:0] sel;

  bcdl_click #(
    .COUNT_BITS(COUNT_BITS)
  ) u_click (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .key_level(key_r),
    .cfg      (cfg_r),
    .click_ev (click_ev)
  );

  bcdl_long #(
    .COUNT_BITS(COUNT_BITS)
  ) u_long (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .key_level(key_r),
    .cfg      (cfg_r),
    .long_fire(long_fire)
  );

  bcdl_serve u_serve (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .click_ev (click_ev),
    .long_fire(long_fire),
    .ev       (ev),
    .sel      (sel)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      ev_res_r  <= ev;
      sel_res_r <= sel;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_event_res = ev_res_r;
  assign out_selection = sel_res_r;

endmodule
